/* rtl/core/isim_pkg.sv */
// shared types and codes for the interval set insert and merge block
package isim_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // one table entry
  typedef struct packed {
    logic signed [31:0] low;
    logic signed [31:0] high;
  } span_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ABS_RD,
    S_ABS_CHK,
    S_MERGE_WR,
    S_MOVE_RD,
    S_MOVE_WR,
    S_INS_WR,
    S_ENTRY,
    S_FIN_LO,
    S_FIN_HI,
    S_FIN_CAP,
    S_DONE
  } state_t;

endpackage

/* rtl/core/isim_cmd_if.sv */
// command channel: valid/ready with one command transaction
interface isim_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic [3:0]         entry_index;

  modport source (output valid, command, value_a, value_b, entry_index, input ready);
  modport sink (input valid, command, value_a, value_b, entry_index, output ready);
endinterface

/* rtl/core/isim_res_if.sv */
// result channel: valid/ready with one result transaction
interface isim_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_low;
  logic signed [31:0] result_high;
  logic [4:0]         entry_count;

  modport source (output valid, status, result_low, result_high, entry_count, input ready);
  modport sink (input valid, status, result_low, result_high, entry_count, output ready);
endinterface

/* rtl/core/isim_ram.sv */
// generic single write, single read ram with registered read data
module isim_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/interval_set_insert_merge.sv */
// Sorted set of disjoint signed 32-bit intervals held in one ram of MAX_INTERVALS
// entries. A sequencer serves one command transaction at a time. A read fetches the
// indexed entry, or reports an out-of-range status when the index is at or beyond
// the count. An insert into an empty table writes the first entry. Any other insert
// scans the table entry by entry, then shifts entries up, absorbs and compacts
// following entries, or appends, and ends with two ram reads for the overall range.
// A finished result also waits for the output register to free up. A new command is
// taken while the previous result still waits at the output. Data read from entries
// at or above the current count is never used.
module interval_set_insert_merge #(
  parameter int MAX_INTERVALS = 16
) (
  input logic        clk,
  input logic        rst,
  isim_cmd_if.sink   cmd,
  isim_res_if.source res
);

  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  isim_pkg::state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      i_ptr, j_ptr, src, dst;
  logic               grow;
  logic signed [31:0] lo, hi;
  isim_pkg::span_t    cur;
  logic [1:0]         st;
  logic signed [31:0] r_low, r_high;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  isim_pkg::span_t    ram_wdata, rdata;

  logic               accept;
  logic               out_free;
  logic signed [31:0] a_min, a_max;
  logic signed [32:0] hi_p1, lo_v, e_low, e_hi_p1, cur_hi_p1;
  logic               gap_before, gap_after, reaches, full;

  isim_ram #(.WIDTH(64), .DEPTH(MAX_INTERVALS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign cmd.ready = (state == isim_pkg::S_IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !res.valid || res.ready;
  assign full      = (count == CW'(MAX_INTERVALS));

  // order the endpoints
  assign a_min = (cmd.value_a < cmd.value_b) ? cmd.value_a : cmd.value_b;
  assign a_max = (cmd.value_a < cmd.value_b) ? cmd.value_b : cmd.value_a;

  // touch tests in 33 bits so the plus one never wraps
  assign hi_p1      = {hi[31], hi} + 33'd1;
  assign lo_v       = {lo[31], lo};
  assign e_low      = {rdata.low[31], rdata.low};
  assign e_hi_p1    = {rdata.high[31], rdata.high} + 33'd1;
  assign cur_hi_p1  = {cur.high[31], cur.high} + 33'd1;
  assign gap_before = hi_p1 < e_low;
  assign gap_after  = e_hi_p1 < lo_v;
  assign reaches    = cur_hi_p1 >= e_low;

  // next state and ram control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    case (state)
      isim_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd.command)
            isim_pkg::CMD_READ: begin
              ram_raddr  = IW'(cmd.entry_index);
              state_next = (32'(cmd.entry_index) < 32'(count)) ? isim_pkg::S_ENTRY
                                                               : isim_pkg::S_DONE;
            end
            isim_pkg::CMD_INSERT: begin
              if (count == '0) begin
                ram_we     = 1'b1;
                ram_wdata  = {a_min, a_max};
                state_next = isim_pkg::S_FIN_LO;
              end else begin
                state_next = isim_pkg::S_SCAN_RD;
              end
            end
            default: state_next = isim_pkg::S_FIN_LO;
          endcase
        end
      end
      isim_pkg::S_SCAN_RD: begin
        ram_raddr  = i_ptr[IW-1:0];
        state_next = isim_pkg::S_SCAN_CHK;
      end
      isim_pkg::S_SCAN_CHK: begin
        if ((32'(i_ptr) + 32'd1 < 32'(count)) && gap_after) begin
          state_next = isim_pkg::S_SCAN_RD;
        end else if (gap_before) begin
          state_next = full ? isim_pkg::S_FIN_LO : isim_pkg::S_MOVE_RD;
        end else if (gap_after) begin
          if (!full) begin
            ram_we    = 1'b1;
            ram_waddr = count[IW-1:0];
            ram_wdata = {lo, hi};
          end
          state_next = isim_pkg::S_FIN_LO;
        end else begin
          state_next = isim_pkg::S_ABS_RD;
        end
      end
      isim_pkg::S_ABS_RD: begin
        ram_raddr  = j_ptr[IW-1:0];
        state_next = (j_ptr < count) ? isim_pkg::S_ABS_CHK : isim_pkg::S_MERGE_WR;
      end
      isim_pkg::S_ABS_CHK: begin
        state_next = reaches ? isim_pkg::S_ABS_RD : isim_pkg::S_MERGE_WR;
      end
      isim_pkg::S_MERGE_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = i_ptr[IW-1:0];
        ram_wdata  = cur;
        state_next = (j_ptr == i_ptr + CW'(1)) ? isim_pkg::S_FIN_LO : isim_pkg::S_MOVE_RD;
      end
      isim_pkg::S_MOVE_RD: begin
        ram_raddr = src[IW-1:0];
        if (!grow && src >= count) begin
          state_next = isim_pkg::S_FIN_LO;
        end else begin
          state_next = isim_pkg::S_MOVE_WR;
        end
      end
      isim_pkg::S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
        if (grow) begin
          ram_waddr  = IW'(src + CW'(1));
          state_next = (src == i_ptr) ? isim_pkg::S_INS_WR : isim_pkg::S_MOVE_RD;
        end else begin
          ram_waddr  = dst[IW-1:0];
          state_next = isim_pkg::S_MOVE_RD;
        end
      end
      isim_pkg::S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = i_ptr[IW-1:0];
        ram_wdata  = {lo, hi};
        state_next = isim_pkg::S_FIN_LO;
      end
      isim_pkg::S_ENTRY:   state_next = isim_pkg::S_DONE;
      isim_pkg::S_FIN_LO: begin
        ram_raddr  = '0;
        state_next = (count == '0) ? isim_pkg::S_DONE : isim_pkg::S_FIN_HI;
      end
      isim_pkg::S_FIN_HI: begin
        ram_raddr  = IW'(count - CW'(1));
        state_next = isim_pkg::S_FIN_CAP;
      end
      isim_pkg::S_FIN_CAP: state_next = isim_pkg::S_DONE;
      isim_pkg::S_DONE: begin
        if (out_free) begin
          state_next = isim_pkg::S_IDLE;
        end
      end
      default: state_next = isim_pkg::S_IDLE;
    endcase
  end

  // state and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isim_pkg::S_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == isim_pkg::S_DONE && out_free) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        isim_pkg::S_IDLE: begin
          if (accept && cmd.command == isim_pkg::CMD_CLEAR) begin
            count <= '0;
          end else if (accept && cmd.command == isim_pkg::CMD_INSERT && count == '0) begin
            count <= CW'(1);
          end
        end
        isim_pkg::S_SCAN_CHK: begin
          if (!((32'(i_ptr) + 32'd1 < 32'(count)) && gap_after) && !gap_before &&
              gap_after && !full) begin
            count <= count + CW'(1);
          end
        end
        isim_pkg::S_MOVE_RD: begin
          if (!grow && src >= count) begin
            count <= dst;
          end
        end
        isim_pkg::S_INS_WR: count <= count + CW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      isim_pkg::S_IDLE: begin
        lo     <= a_min;
        hi     <= a_max;
        i_ptr  <= '0;
        r_low  <= '0;
        r_high <= '0;
        st     <= (accept && cmd.command == isim_pkg::CMD_READ &&
                   !(32'(cmd.entry_index) < 32'(count))) ? isim_pkg::ST_RANGE
                                                         : isim_pkg::ST_OK;
      end
      isim_pkg::S_SCAN_CHK: begin
        if ((32'(i_ptr) + 32'd1 < 32'(count)) && gap_after) begin
          i_ptr <= i_ptr + CW'(1);
        end else if (gap_before || gap_after) begin
          if (full) begin
            st <= isim_pkg::ST_FULL;
          end
          grow <= 1'b1;
          src  <= count - CW'(1);
        end else begin
          cur.low  <= (lo < rdata.low) ? lo : rdata.low;
          cur.high <= (hi > rdata.high) ? hi : rdata.high;
          j_ptr    <= i_ptr + CW'(1);
        end
      end
      isim_pkg::S_ABS_CHK: begin
        if (reaches) begin
          if (rdata.high > cur.high) begin
            cur.high <= rdata.high;
          end
          j_ptr <= j_ptr + CW'(1);
        end
      end
      isim_pkg::S_MERGE_WR: begin
        grow <= 1'b0;
        src  <= j_ptr;
        dst  <= i_ptr + CW'(1);
      end
      isim_pkg::S_MOVE_WR: begin
        if (grow) begin
          src <= src - CW'(1);
        end else begin
          src <= src + CW'(1);
          dst <= dst + CW'(1);
        end
      end
      isim_pkg::S_ENTRY: begin
        r_low  <= rdata.low;
        r_high <= rdata.high;
      end
      isim_pkg::S_FIN_HI:  r_low  <= rdata.low;
      isim_pkg::S_FIN_CAP: r_high <= rdata.high;
      isim_pkg::S_DONE: begin
        if (out_free) begin
          res.status      <= st;
          res.result_low  <= r_low;
          res.result_high <= r_high;
          res.entry_count <= 5'(count);
        end
      end
      default: ;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_INTERVALS))
    else $error("entry count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == isim_pkg::CMD_CLEAR |=> count == '0)
    else $error("clear did not empty the table");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == isim_pkg::ST_RANGE |-> res.result_low == 0 &&
    res.result_high == 0)
    else $error("out of range read returned nonzero bounds");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == isim_pkg::S_DONE && out_free |=> res.valid && state == isim_pkg::S_IDLE)
    else $error("finished transaction not presented");

endmodule
